// ----- rtl/mtwg_pkg.sv -----
// Shared constants and types for the MT19937 word generator.
package mtwg_pkg;

	localparam int STATE_WORDS_DEF  = 624;
	localparam int TWIST_OFFSET_DEF = 397;
	localparam int SCRAMBLE_STEPS   = 50;

	localparam logic [31:0] LCG_MUL   = 32'd69069;
	localparam logic [31:0] LCG_ADD   = 32'd1;
	localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCRAMBLE,
		ST_FILL,
		ST_READ,
		ST_TWIST
	} ctrl_state_t;

	typedef struct packed {
		logic load_seed;
		logic scramble;
		logic fill;
		logic read;
		logic twist;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scramble_last;
		logic fill_last;
		logic out_busy;
	} ctrl_status_t;

endpackage

// ----- rtl/mtwg_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module mtwg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule

// ----- rtl/mtwg_ctrl.sv -----
// Controller state machine: request handshake, seeding sequence and twist steps.
module mtwg_ctrl
	import mtwg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic         restart,
	output ctrl_cmd_t    cmd,
	input  ctrl_status_t status
);

	ctrl_state_t state_q, state_d;
	logic        needs_seed_q, needs_seed_d;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			needs_seed_q <= 1'b1;
		end else begin
			state_q      <= state_d;
			needs_seed_q <= needs_seed_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d      = state_q;
		needs_seed_d = needs_seed_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (restart || needs_seed_q) begin
						cmd.load_seed = 1'b1;
						state_d       = ST_SCRAMBLE;
					end else begin
						cmd.read = 1'b1;
						state_d  = ST_TWIST;
					end
				end
			end
			ST_SCRAMBLE: begin
				cmd.scramble = 1'b1;
				if (status.scramble_last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (status.fill_last) begin
					needs_seed_d = 1'b0;
					state_d      = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_TWIST;
			end
			ST_TWIST: begin
				if (!status.out_busy) begin
					cmd.twist = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/mtwg_datapath.sv -----
// Datapath: seed register, LCG seeding, state memory, twist, tempering and output register.
module mtwg_datapath
	import mtwg_pkg::*;
#(
	parameter int STATE_WORDS  = STATE_WORDS_DEF,
	parameter int TWIST_OFFSET = TWIST_OFFSET_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         seed_we,
	input  logic [31:0]  seed,
	input  ctrl_cmd_t    cmd,
	output ctrl_status_t status,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [31:0]  random_word
);

	localparam int IDX_W = $clog2(STATE_WORDS);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);
	localparam logic [IDX_W:0]   OFFSET_EXT = (IDX_W+1)'(TWIST_OFFSET);
	localparam logic [IDX_W:0]   WORDS_EXT  = (IDX_W+1)'(STATE_WORDS);

	logic [31:0]      seed_q;
	logic [31:0]      x_q;
	logic [31:0]      cur_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] index_q;
	logic             out_valid_q;
	logic [31:0]      out_word_q;

	logic [31:0]      lcg_val;
	logic [IDX_W-1:0] next_idx;
	logic [IDX_W:0]   far_sum;
	logic [IDX_W-1:0] far_idx;
	logic [31:0]      rd0;
	logic [31:0]      rd1;
	logic [31:0]      y;
	logic [31:0]      twisted;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [31:0]      ram_wdata;

	function automatic logic [31:0] temper(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

	assign lcg_val  = 32'(x_q * LCG_MUL) + LCG_ADD;
	assign next_idx = (index_q == LAST_IDX) ? '0 : index_q + IDX_ONE;
	assign far_sum  = {1'b0, index_q} + OFFSET_EXT;
	assign far_idx  = (far_sum >= WORDS_EXT) ? IDX_W'(far_sum - WORDS_EXT) : far_sum[IDX_W-1:0];

	assign y       = {cur_q[31], rd0[30:0]};
	assign twisted = rd1 ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);

	assign ram_we    = cmd.fill || cmd.twist;
	assign ram_waddr = cmd.fill ? cnt_q : index_q;
	assign ram_wdata = cmd.fill ? lcg_val : twisted;

	mtwg_ram #(
		.WIDTH (32),
		.DEPTH (STATE_WORDS)
	) u_state_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (cmd.read),
		.raddr0 (next_idx),
		.raddr1 (far_idx),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	assign status.scramble_last = (cnt_q == IDX_W'(SCRAMBLE_STEPS));
	assign status.fill_last     = (cnt_q == LAST_IDX);
	assign status.out_busy      = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			cnt_q       <= '0;
			index_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed;
			end
			if (cmd.load_seed) begin
				cnt_q <= '0;
			end else if (cmd.scramble) begin
				cnt_q <= status.scramble_last ? '0 : cnt_q + IDX_ONE;
			end else if (cmd.fill) begin
				cnt_q <= status.fill_last ? '0 : cnt_q + IDX_ONE;
			end
			if (cmd.fill && status.fill_last) begin
				index_q <= '0;
			end else if (cmd.twist) begin
				index_q <= next_idx;
			end
			if (cmd.twist) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			x_q <= seed_q;
		end else if (cmd.scramble || cmd.fill) begin
			x_q <= lcg_val;
		end
		if (cmd.fill && cnt_q == '0) begin
			cur_q <= lcg_val;
		end else if (cmd.twist) begin
			cur_q <= rd0;
		end
		if (cmd.twist) begin
			out_word_q <= temper(twisted);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

endmodule

// ----- rtl/mt19937_word_generator.sv -----
// Top level of the MT19937 word generator.
//
// Request channel: in_valid / in_stall with the restart bit. A request is
// taken when in_valid is high and in_stall is low; each request yields one
// tempered 32-bit word on the word channel (out_valid / out_stall, random_word).
// The seed register is written through seed_we / seed; the user must write it
// only while idle, the block itself does not enforce this. Without seeding, a
// request reads the next state word and the word TWIST_OFFSET (397 by default)
// places ahead from the two read ports of the state memory, then twists, writes
// back and tempers into the output register; a new request is taken only after
// the twist. A request with restart set, or the first request after reset, first
// seeds the state: the seed is loaded and scrambled by LCG steps, all STATE_WORDS
// memory words are filled with LCG values, and a read step precedes the twist.
// Reset clears the seed to 0 and marks the state as unseeded; the memory
// itself is not cleared. While the receiver stalls a waiting word, the word
// is held and the next request is taken, but its twist waits until the
// output register frees.
module mt19937_word_generator
	import mtwg_pkg::*;
#(
	parameter int STATE_WORDS  = STATE_WORDS_DEF,
	parameter int TWIST_OFFSET = TWIST_OFFSET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] random_word,
	input  logic        seed_we,
	input  logic [31:0] seed
);

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	mtwg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.cmd      (cmd),
		.status   (status)
	);

	mtwg_datapath #(
		.STATE_WORDS  (STATE_WORDS),
		.TWIST_OFFSET (TWIST_OFFSET)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_we     (seed_we),
		.seed        (seed),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

endmodule
